[design/rpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types, codes and helpers of the request path percent decoder.
// ----------------------------------------------------------------------------
package rpd_pkg;

  // Path status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SEP  = 2'd1;
  localparam logic [1:0] ST_UTF8 = 2'd2;

  // Range limit on the next UTF-8 continuation byte
  localparam logic [2:0] CLS_NONE = 3'd0;  // 80-BF
  localparam logic [2:0] CLS_A0   = 3'd1;  // A0-BF
  localparam logic [2:0] CLS_9F   = 3'd2;  // 80-9F
  localparam logic [2:0] CLS_90   = 3'd3;  // 90-BF
  localparam logic [2:0] CLS_8F   = 3'd4;  // 80-8F

  // Held lookahead byte counts
  localparam logic [1:0] HC_NONE = 2'd0;
  localparam logic [1:0] HC_ONE  = 2'd1;
  localparam logic [1:0] HC_TWO  = 2'd2;

  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Results one item can produce
  localparam int unsigned MaxRes = 3;

  typedef struct packed {
    logic [1:0] rem;   // continuation bytes still expected
    logic [2:0] cls;   // range class of the next continuation byte
    logic [1:0] err;   // sticky status
  } rpd_utf8_t;

  typedef struct packed {
    logic [1:0] held_count;
    logic [7:0] held0;     // held '%'
    logic [7:0] held1;     // held first hex digit
    rpd_utf8_t  utf8;
  } rpd_ctx_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
    logic [1:0] status;
  } rpd_res_t;

  function automatic logic hex_ok(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

[design/request_path_percent_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_path_percent_decoder_core
// Percent decoder for request paths with strict UTF-8 checking.
// ----------------------------------------------------------------------------
// Takes a request path one byte per item, in_last_i on its final byte, and
// gives out decoded path bytes one result item at a time. "%hh" (hex, either
// case) becomes one byte; any other '%' passes through. An encoded '/' or
// backslash sets status 1 and drops every later byte of the path; bad UTF-8
// (overlong, surrogate, above U+10FFFF, cut off at the end) sets status 2.
// The result flagged out_last_o carries the status of the whole path; a path
// whose final item yields no byte ends in one result with has_byte_o low.
// Timing: an item is decoded in the cycle it is accepted and its results
// (zero to three) land in a three-entry result buffer that drains one result
// per cycle while out_stall_i is low. An item yielding at most one result is
// taken every cycle unless the output stalls; one yielding more stalls the
// input while they drain. Its first result is on the port the next cycle.
// ----------------------------------------------------------------------------
module request_path_percent_decoder_core import rpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       out_last_o,
  output logic [1:0] status_o
);

  // Decoder context: held lookahead bytes and UTF-8 tracking
  rpd_ctx_t   ctx_q;
  rpd_ctx_t   ctx_d;

  // Step results of the item at the port
  rpd_res_t   step_res [MaxRes];
  logic [1:0] step_n;

  // Result buffer, head at entry 0
  rpd_res_t   buf_q [MaxRes];
  logic [1:0] cnt_q;

  logic       in_acc;
  logic       out_pop;

  rpd_step u_step (
    .ctx_i   (ctx_q),
    .byte_i  (in_byte_i),
    .last_i  (in_last_i),
    .ctx_o   (ctx_d),
    .res_o   (step_res),
    .res_n_o (step_n)
  );

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_pop     = out_valid_o && !out_stall_i;
  // Room for a whole batch once the buffer is empty or its last entry leaves
  assign in_stall_o  = !((cnt_q == 2'd0) || (cnt_q == 2'd1 && out_pop));
  assign in_acc      = in_valid_i && !in_stall_o;

  assign out_byte_o = buf_q[0].data;
  assign has_byte_o = buf_q[0].has_byte;
  assign out_last_o = buf_q[0].last;
  assign status_o   = buf_q[0].status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= '0;
      cnt_q <= 2'd0;
    end else begin
      if (in_acc) begin
        ctx_q <= ctx_d;
        cnt_q <= step_n;
      end else if (out_pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // Payload: load a fresh batch, or shift toward the head on a pop
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < MaxRes; k++) begin
        buf_q[k] <= step_res[k];
      end
    end else if (out_pop) begin
      for (int k = 0; k < MaxRes - 1; k++) begin
        buf_q[k] <= buf_q[k+1];
      end
    end
  end

`ifndef ASSERT_OFF
  // Context returns to reset after the final byte of a path
  a_path_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_last_i) |=> (ctx_q == '0))
    else $error("context not cleared after path end");

  // Lookahead never holds more than two bytes
  a_held_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctx_q.held_count != 2'd3)
    else $error("held count out of range");

  // A separator drops all later bytes, so it only shows on the final empty result
  a_sep_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_SEP) |-> (out_last_o && !has_byte_o))
    else $error("separator status on a byte result");

  // A result without a byte is always the end of a path
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_byte_o) |-> out_last_o)
    else $error("empty result that is not last");
`endif

endmodule

[design/rpd_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_emit
// One decoded byte out: strict UTF-8 tracking and the result it makes.
// ----------------------------------------------------------------------------
module rpd_emit import rpd_pkg::*; (
  input  logic      en_i,
  input  logic [7:0] byte_i,
  input  rpd_utf8_t st_i,
  output rpd_utf8_t st_o,
  output logic      vld_o,
  output rpd_res_t  res_o
);

  logic [7:0] lo;
  logic [7:0] hi;
  rpd_utf8_t  nx;
  logic       fail;

  always_comb begin
    lo   = 8'h80;
    hi   = 8'hBF;
    nx   = st_i;
    fail = 1'b0;
    case (st_i.cls)
      CLS_A0:  lo = 8'hA0;
      CLS_9F:  hi = 8'h9F;
      CLS_90:  lo = 8'h90;
      CLS_8F:  hi = 8'h8F;
      default: ;
    endcase

    nx.cls = CLS_NONE;
    if (st_i.rem != 2'd0) begin
      if (byte_i < lo || byte_i > hi) begin
        fail = 1'b1;
      end else begin
        nx.rem = st_i.rem - 2'd1;
      end
    end else if (byte_i < 8'h80) begin
      nx.rem = 2'd0;
    end else if (byte_i >= 8'hC2 && byte_i <= 8'hDF) begin
      nx.rem = 2'd1;
    end else if (byte_i >= 8'hE0 && byte_i <= 8'hEF) begin
      nx.rem = 2'd2;
      if (byte_i == 8'hE0) nx.cls = CLS_A0;
      else if (byte_i == 8'hED) nx.cls = CLS_9F;
    end else if (byte_i >= 8'hF0 && byte_i <= 8'hF4) begin
      nx.rem = 2'd3;
      if (byte_i == 8'hF0) nx.cls = CLS_90;
      else if (byte_i == 8'hF4) nx.cls = CLS_8F;
    end else begin
      fail = 1'b1;
    end

    if (fail) begin
      nx.rem = 2'd0;
      nx.cls = CLS_NONE;
      if (st_i.err == ST_OK) nx.err = ST_UTF8;
    end

    // Bytes after an encoded separator are dropped
    vld_o = en_i && (st_i.err != ST_SEP);
    st_o  = vld_o ? nx : st_i;

    res_o.data     = byte_i;
    res_o.has_byte = 1'b1;
    res_o.last     = 1'b0;
    res_o.status   = nx.err;
  end

endmodule

[design/rpd_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_step
// Percent lookahead for one path byte: next context and up to three results.
// ----------------------------------------------------------------------------
module rpd_step import rpd_pkg::*; (
  input  rpd_ctx_t   ctx_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output rpd_ctx_t   ctx_o,
  output rpd_res_t   res_o [MaxRes],
  output logic [1:0] res_n_o
);

  logic       en   [MaxRes];
  logic [7:0] eb   [MaxRes];
  rpd_utf8_t  est  [MaxRes+1];
  logic       evld [MaxRes];
  rpd_res_t   eres [MaxRes];

  logic       pct_hold;
  logic       sep;
  logic [7:0] dec;
  logic [1:0] hc_d;
  logic [7:0] h0_d;
  logic [7:0] h1_d;
  logic [1:0] n;
  logic [1:0] st_fin;
  rpd_utf8_t  u_fin;

  assign pct_hold = (byte_i == CH_PCT) && !last_i;
  assign dec      = {hex_val(ctx_i.held1), hex_val(byte_i)};

  always_comb begin
    for (int k = 0; k < MaxRes; k++) begin
      en[k] = 1'b0;
      eb[k] = byte_i;
    end
    sep  = 1'b0;
    hc_d = HC_NONE;
    h0_d = ctx_i.held0;
    h1_d = ctx_i.held1;
    case (ctx_i.held_count)
      HC_ONE: begin
        if (hex_ok(byte_i) && !last_i) begin
          hc_d = HC_TWO;
          h1_d = byte_i;
        end else begin
          en[0] = 1'b1;
          eb[0] = ctx_i.held0;
          if (pct_hold) begin
            hc_d = HC_ONE;
            h0_d = byte_i;
          end else begin
            en[1] = 1'b1;
          end
        end
      end
      HC_TWO: begin
        if (hex_ok(ctx_i.held1) && hex_ok(byte_i)) begin
          if (dec == CH_SLASH || dec == CH_BSLASH) begin
            sep = 1'b1;
          end else begin
            en[0] = 1'b1;
            eb[0] = dec;
          end
        end else begin
          en[0] = 1'b1;
          eb[0] = ctx_i.held0;
          en[1] = 1'b1;
          eb[1] = ctx_i.held1;
          if (pct_hold) begin
            hc_d = HC_ONE;
            h0_d = byte_i;
          end else begin
            en[2] = 1'b1;
          end
        end
      end
      default: begin
        if (pct_hold) begin
          hc_d = HC_ONE;
          h0_d = byte_i;
        end else begin
          en[0] = 1'b1;
        end
      end
    endcase
  end

  assign est[0] = ctx_i.utf8;

  for (genvar g = 0; g < MaxRes; g++) begin : g_emit
    rpd_emit u_emit (
      .en_i   (en[g]),
      .byte_i (eb[g]),
      .st_i   (est[g]),
      .st_o   (est[g+1]),
      .vld_o  (evld[g]),
      .res_o  (eres[g])
    );
  end

  // Enabled slots form a prefix, so the valid results do too
  always_comb begin
    u_fin = est[MaxRes];
    if (sep) u_fin.err = ST_SEP;
    n = 2'({1'b0, evld[0]} + {1'b0, evld[1]} + {1'b0, evld[2]});

    st_fin = u_fin.err;
    if (st_fin == ST_OK && u_fin.rem != 2'd0) st_fin = ST_UTF8;

    for (int k = 0; k < MaxRes; k++) begin
      res_o[k] = eres[k];
    end

    ctx_o.held_count = hc_d;
    ctx_o.held0      = h0_d;
    ctx_o.held1      = h1_d;
    ctx_o.utf8       = u_fin;

    if (last_i) begin
      case (n)
        2'd0: begin
          res_o[0] = '{data: 8'h00, has_byte: 1'b0, last: 1'b1, status: st_fin};
          n = 2'd1;
        end
        2'd1: begin
          res_o[0].last   = 1'b1;
          res_o[0].status = st_fin;
        end
        2'd2: begin
          res_o[1].last   = 1'b1;
          res_o[1].status = st_fin;
        end
        default: begin
          res_o[2].last   = 1'b1;
          res_o[2].status = st_fin;
        end
      endcase
      ctx_o = '0;
    end
    res_n_o = n;
  end

endmodule
